// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the embedding update core.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define EAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next
`define EAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EAU_ASSERT(lbl, prop)
`define EAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/eau_pkg.sv
// Shared constants and controller/datapath interface types of the update core.
// No dependencies.
package eau_pkg;

  localparam int unsigned DIM       = 64;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned ACCUM_W   = 40;
  localparam int unsigned GRAD_W    = 32;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned FRAC_W    = 28;

  localparam logic [IDX_W-1:0]  DIM_IDX   = IDX_W'(DIM);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DIM - 1);
  localparam logic [31:0]       EPS_Q26   = 32'd7;
  localparam logic [33:0]       DELTA_CAP = 34'h2_0000_0000;
  localparam logic [SUM_W-1:0]  ONE_Q28   = SUM_W'(64'd1 << 28);

  // Configuration register indexes
  localparam logic CFG_USE_ADAGRAD = 1'b0;
  localparam logic CFG_RATE        = 1'b1;

  // Divider operand selection
  localparam logic [1:0] DIV_GRAD  = 2'd0;
  localparam logic [1:0] DIV_DELTA = 2'd1;
  localparam logic [1:0] DIV_SGD   = 2'd2;
  localparam logic [1:0] DIV_NORM  = 2'd3;

  // Multiplier operand selection
  localparam logic [1:0] MUL_GG = 2'd0;
  localparam logic [1:0] MUL_RG = 2'd1;
  localparam logic [1:0] MUL_RU = 2'd2;
  localparam logic [1:0] MUL_WW = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       gmag_ld;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_upd;
    logic       sqrt_start;
    logic       div_start;
    logic [1:0] div_sel;
    logic       w_upd;
    logic       sq_acc;
    logic       emit_clr;
    logic       emit_inc;
    logic       rd_en;
    logic       out_load;
    logic       clr;
  } eau_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic idx_full;
    logic cnt_zero;
    logic last;
    logic adagrad;
    logic norm;
    logic emit_last;
    logic out_valid;
  } eau_sts_t;

endpackage

// File: src/eau_div.sv
// Iterative restoring divider, one quotient bit per cycle, 64-bit quotient.
// Depends on eau_pkg for operand widths.
module eau_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [eau_pkg::NUM_W-1:0]  num_i,
  input  logic [eau_pkg::SUM_W-1:0]  den_i,
  output logic                       done_o,
  output logic [eau_pkg::NUM_W-1:0]  quot_o
);
  import eau_pkg::*;

  localparam logic [5:0] LAST_STEP = 6'(NUM_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [5:0]       step_q;
  logic [SUM_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [SUM_W:0]   shifted;
  logic             fits;

  // Trial subtraction of the shifted remainder
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == LAST_STEP) busy_q <= 1'b0;
      end
    end
  end

  // Shift in one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? SUM_W'(shifted - {1'b0, den_q}) : shifted[SUM_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: src/eau_sqrt.sv
// Iterative integer square root, one root bit per cycle, 32-bit root.
// Depends on eau_pkg for the radicand width.
module eau_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [eau_pkg::NUM_W-1:0] rad_i,
  output logic                      done_o,
  output logic [31:0]               root_o
);
  import eau_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [4:0]       step_q;
  logic [NUM_W-1:0] rad_q;
  logic [33:0]      rem_q;
  logic [31:0]      root_q;
  logic [35:0]      part;
  logic [35:0]      trial;
  logic             fits;

  // Bring down two radicand bits and try the next root bit
  assign part  = {rem_q, rad_q[NUM_W-1:NUM_W-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = part >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[NUM_W-3:0], 2'b00};
      rem_q  <= fits ? 34'(part - trial) : part[33:0];
      root_q <= {root_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: src/eau_dp.sv
// Datapath: input and config registers, shared multiplier, divider and root
// units, vector buffers and output register. Depends on eau_pkg, eau_div, eau_sqrt.
module eau_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  eau_pkg::eau_cmd_t           cmd_i,
  output eau_pkg::eau_sts_t           sts_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic [119:0]                in_data_i,
  input  logic                        in_user_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [71:0]                 out_data_o,
  output logic                        out_last_o
);
  import eau_pkg::*;

  logic                use_adagrad_q;
  logic [31:0]         rate_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [ACCUM_W-1:0]  acc_q;
  logic [GRAD_W-1:0]   grad_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                ent_q, last_q;
  logic [31:0]         gmag_q;
  logic [63:0]         prod_q;
  logic [31:0]         mul_a, mul_b;
  logic [31:0]         grad_mag, w_mag;
  logic [SUM_W-1:0]    sum_q;
  logic [IDX_W-1:0]    idx_q;
  logic [ADDR_W-1:0]   emit_q;
  logic [WEIGHT_W-1:0] weight_mem [DIM];
  logic [ACCUM_W-1:0]  accum_mem [DIM];
  logic [WEIGHT_W-1:0] rd_w_q;
  logic [ACCUM_W-1:0]  rd_acc_q;
  logic                out_valid_q;
  logic [WEIGHT_W-1:0] out_w_q;
  logic [ACCUM_W-1:0]  out_acc_q;
  logic                out_last_q;

  logic                div_done;
  logic [NUM_W-1:0]    div_num, div_quot;
  logic [SUM_W-1:0]    div_den;
  logic                sqrt_done;
  logic [31:0]         root, root_eff;
  logic [ACCUM_W:0]    acc_sum;
  logic [SUM_W:0]      sq_sum;
  logic [NUM_W-1:0]    delta_raw;
  logic [33:0]         delta;
  logic [35:0]         w_wide;
  logic [WEIGHT_W-1:0] w_sat;
  logic [31:0]         rd_mag;
  logic                norm;
  logic [WEIGHT_W-1:0] norm_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_adagrad_q <= 1'b1;
      rate_q        <= 32'd26843546;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_USE_ADAGRAD: use_adagrad_q <= cfg_data_i[0];
        CFG_RATE:        rate_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Magnitudes of signed operands
  assign grad_mag = grad_q[GRAD_W-1] ? 32'(-grad_q) : grad_q;
  assign w_mag    = w_q[WEIGHT_W-1] ? 32'(-w_q) : w_q;
  assign rd_mag   = rd_w_q[WEIGHT_W-1] ? 32'(-rd_w_q) : rd_w_q;

  // Shared multiplier, registered product
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_GG:  begin mul_a = gmag_q; mul_b = gmag_q;   end
      MUL_RG:  begin mul_a = rate_q; mul_b = gmag_q;   end
      MUL_RU:  begin mul_a = rate_q; mul_b = grad_mag; end
      MUL_WW:  begin mul_a = w_mag;  mul_b = w_mag;    end
      default: begin mul_a = w_mag;  mul_b = w_mag;    end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Divider operands
  assign root_eff = (root < EPS_Q26) ? EPS_Q26 : root;
  always_comb begin
    case (cmd_i.div_sel)
      DIV_GRAD:  begin div_num = NUM_W'(grad_mag);  div_den = SUM_W'(cnt_q); end
      DIV_DELTA: begin div_num = prod_q; div_den = SUM_W'({root_eff, 2'b00}); end
      DIV_SGD:   begin div_num = prod_q;            div_den = SUM_W'(cnt_q); end
      DIV_NORM:  begin div_num = NUM_W'({rd_mag, 28'd0}); div_den = sum_q;    end
      default:   begin div_num = prod_q;            div_den = sum_q;          end
    endcase
  end

  eau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  eau_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   ({acc_q, 24'd0}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Accumulator and square-sum updates, saturating
  assign acc_sum = {1'b0, acc_q} + (ACCUM_W+1)'(prod_q[63:FRAC_W]);
  assign sq_sum  = {1'b0, sum_q} + (SUM_W+1)'(prod_q[63:FRAC_W]);

  // Weight step: cap the delta and saturate the result
  assign delta_raw = use_adagrad_q ? div_quot : (div_quot >> FRAC_W);
  assign delta     = (delta_raw > NUM_W'(DELTA_CAP)) ? DELTA_CAP : delta_raw[33:0];
  assign w_wide    = grad_q[GRAD_W-1] ? (36'(signed'(w_q)) + 36'(delta))
                                      : (36'(signed'(w_q)) - 36'(delta));
  always_comb begin
    if (!w_wide[35] && (w_wide[34:31] != 4'b0000)) w_sat = 32'h7FFF_FFFF;
    else if (w_wide[35] && (w_wide[34:31] != 4'b1111)) w_sat = 32'h8000_0000;
    else w_sat = w_wide[31:0];
  end

  // Input item and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      w_q    <= in_data_i[31:0];
      acc_q  <= in_data_i[71:32];
      grad_q <= in_data_i[103:72];
      cnt_q  <= in_data_i[119:104];
      ent_q  <= in_user_i;
      last_q <= in_last_i;
    end else begin
      if (cmd_i.acc_upd) acc_q <= acc_sum[ACCUM_W] ? '1 : acc_sum[ACCUM_W-1:0];
      if (cmd_i.w_upd)   w_q   <= w_sat;
    end
    if (cmd_i.gmag_ld) gmag_q <= div_quot[31:0];
  end

  // Element index and running square sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.clr) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.sq_acc) begin
      idx_q <= idx_q + IDX_W'(1);
      sum_q <= sq_sum[SUM_W] ? '1 : sq_sum[SUM_W-1:0];
    end
  end

  // Vector buffers
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_acc) begin
      weight_mem[idx_q[ADDR_W-1:0]] <= w_q;
      accum_mem[idx_q[ADDR_W-1:0]]  <= acc_q;
    end
    if (cmd_i.rd_en) begin
      rd_w_q   <= weight_mem[emit_q];
      rd_acc_q <= accum_mem[emit_q];
    end
  end

  // Emission counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_q <= '0;
    else if (cmd_i.emit_clr) emit_q <= '0;
    else if (cmd_i.emit_inc) emit_q <= emit_q + ADDR_W'(1);
  end

  // Normalisation decision and scaled weight
  assign norm   = ent_q && (cnt_q != '0) && (sum_q > ONE_Q28);
  assign norm_w = rd_w_q[WEIGHT_W-1] ? 32'(-div_quot[31:0]) : div_quot[31:0];

  // Output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_w_q    <= norm ? norm_w : rd_w_q;
      out_acc_q  <= rd_acc_q;
      out_last_q <= (emit_q == LAST_ADDR);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_acc_q, out_w_q};
  assign out_last_o  = out_last_q;

  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.idx_full  = idx_q >= DIM_IDX;
  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.last      = last_q;
  assign sts_o.adagrad   = use_adagrad_q;
  assign sts_o.norm      = norm;
  assign sts_o.emit_last = emit_q == LAST_ADDR;
  assign sts_o.out_valid = out_valid_q;

endmodule

// File: src/eau_ctrl.sv
// Controller state machine: sequences the per-element update and the emission.
// Depends on eau_pkg for the command and status types.
module eau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  eau_pkg::eau_sts_t sts_i,
  output eau_pkg::eau_cmd_t cmd_o
);
  import eau_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_DIVG   = 4'd2;
  localparam logic [3:0] S_MULGG  = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_SQRTS  = 4'd5;
  localparam logic [3:0] S_SQRTW  = 4'd6;
  localparam logic [3:0] S_DIVDS  = 4'd7;
  localparam logic [3:0] S_SGDDIV = 4'd8;
  localparam logic [3:0] S_DIVW   = 4'd9;
  localparam logic [3:0] S_SQM    = 4'd10;
  localparam logic [3:0] S_SQA    = 4'd11;
  localparam logic [3:0] S_EMRD   = 4'd12;
  localparam logic [3:0] S_EMDAT  = 4'd13;
  localparam logic [3:0] S_EMDIV  = 4'd14;
  localparam logic [3:0] S_EMOUT  = 4'd15;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.idx_full) begin
          cmd_o.emit_clr = 1'b1;
          state_d = sts_i.last ? S_EMRD : S_IDLE;
        end else if (sts_i.cnt_zero) begin
          state_d = S_SQM;
        end else if (sts_i.adagrad) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GRAD;
          state_d = S_DIVG;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_RU;
          state_d = S_SGDDIV;
        end
      end
      S_DIVG: begin
        if (sts_i.div_done) begin
          cmd_o.gmag_ld = 1'b1;
          state_d = S_MULGG;
        end
      end
      S_MULGG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GG;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d = S_SQRTS;
      end
      S_SQRTS: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRTW;
      end
      S_SQRTW: begin
        if (sts_i.sqrt_done) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_RG;
          state_d = S_DIVDS;
        end
      end
      S_DIVDS: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DELTA;
        state_d = S_DIVW;
      end
      S_SGDDIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SGD;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.w_upd = 1'b1;
          state_d = S_SQM;
        end
      end
      S_SQM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_WW;
        state_d = S_SQA;
      end
      S_SQA: begin
        cmd_o.sq_acc   = 1'b1;
        cmd_o.emit_clr = 1'b1;
        state_d = sts_i.last ? S_EMRD : S_IDLE;
      end
      S_EMRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_EMDAT;
      end
      S_EMDAT: begin
        if (sts_i.norm) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_NORM;
          state_d = S_EMDIV;
        end else begin
          cmd_o.out_load = 1'b1;
          state_d = S_EMOUT;
        end
      end
      S_EMDIV: begin
        cmd_o.div_sel = DIV_NORM;
        if (sts_i.div_done) begin
          cmd_o.out_load = 1'b1;
          state_d = S_EMOUT;
        end
      end
      S_EMOUT: begin
        // Wait for the beat to be taken, then advance or finish
        if (!sts_i.out_valid) begin
          if (sts_i.emit_last) begin
            cmd_o.clr = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_inc = 1'b1;
            state_d = S_EMRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: src/embedding_adagrad_update_core.sv
// Embedding vector Adagrad/SGD update core, top level.
// Depends on eau_pkg, eau_ctrl, eau_dp and assert_macros.svh.
//
// Usage: elements of one vector arrive on the s_axis stream, one beat each,
// tlast on the final element and tuser set for entity vectors. The first DIM
// elements are updated (unless their count is zero) and buffered; after the
// tlast beat the core emits DIM updated elements (weight and accumulator) on
// m_axis, tlast on the last of them. Configuration (use_adagrad at index 0,
// learning_rate at index 1) is written through cfg_we_i; the user must write
// it only while the core is idle, which the core itself does not enforce.
// Elements are processed one at a time. An Adagrad element passes through two
// divides and a square root, a plain SGD element through one divide; an element
// with zero count skips the update and one beyond DIM is dropped. In emission
// each element passes through the divider when the vector is normalised.
// Reset clears the element index, square sum and configuration to defaults;
// buffer contents are undefined until written. When the receiver stalls the
// output beat is held and the core waits; no input is taken until the whole
// vector has been delivered.
module embedding_adagrad_update_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // weight_in, accum_in, grad_sum, update_count
  input  logic         s_axis_tuser,  // is_entity
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // weight_out, accum_out
  output logic         m_axis_tlast
);
  import eau_pkg::*;
  `include "assert_macros.svh"

  eau_cmd_t cmd;
  eau_sts_t sts;

  eau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eau_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Input is never taken while a result beat is pending
  `EAU_ASSERT(a_no_overlap, !(m_axis_tvalid && s_axis_tready))
  // An accepted beat drops ready until its work is done
  `EAU_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // The final result beat ends the emission
  `EAU_ASSERT_NEXT(a_last_ends, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule
